// ===== hw/rtl/mb_pkg.sv =====
// Shared types, widths and register indexes for the escape-time evaluator.
package mb_pkg;

  localparam int WORD_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int POS_W     = 10;
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

  localparam logic signed [WORD_W-1:0] ORIGIN_RST   = -32'sd536870912;
  localparam logic signed [WORD_W-1:0] STEP_RST     = 32'sd1049625;
  localparam logic        [CNT_W-1:0]  MAX_ITER_RST = 16'd1000;

  typedef struct packed {
    logic signed [WORD_W-1:0] origin_x;
    logic signed [WORD_W-1:0] origin_y;
    logic signed [WORD_W-1:0] step_x;
    logic signed [WORD_W-1:0] step_y;
    logic        [CNT_W-1:0]  max_iter;
  } cfg_t;

  typedef struct packed {
    logic        [POS_W-1:0]  out_col;
    logic        [POS_W-1:0]  out_row;
    logic        [CNT_W-1:0]  iter_count;
    logic                     escaped;
    logic signed [WORD_W-1:0] final_re;
    logic signed [WORD_W-1:0] final_im;
  } res_t;

endpackage

// ===== hw/rtl/mb_pix_if.sv =====
// Pixel input channel.
interface mb_pix_if import mb_pkg::*;;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pixel_col;
  logic [POS_W-1:0] pixel_row;

  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink (input valid, input pixel_col, input pixel_row, output ready);
endinterface

// ===== hw/rtl/mb_res_if.sv =====
// Result output channel.
interface mb_res_if import mb_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic        [POS_W-1:0]  out_col;
  logic        [POS_W-1:0]  out_row;
  logic        [CNT_W-1:0]  iter_count;
  logic                     escaped;
  logic signed [WORD_W-1:0] final_re;
  logic signed [WORD_W-1:0] final_im;

  modport source (output valid, output out_col, output out_row, output iter_count,
                  output escaped, output final_re, output final_im, input ready);
  modport sink (input valid, input out_col, input out_row, input iter_count,
                input escaped, input final_re, input final_im, output ready);
endinterface

// ===== hw/rtl/mb_cfg_if.sv =====
// Configuration write channel.
interface mb_cfg_if import mb_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time evaluator: one pixel at a time, shared 32x32 multiplier.
// Each iteration steps through zr*zr, zi*zi and zr*zi on the multiplier, then the update.
// The next pixel is taken as soon as the result moves into the output register;
// until then the pixel input is not ready.
// Reset (rst, synchronous): idle, output empty, registers at their defaults.
module mandelbrot_escape_time import mb_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input logic       clk,
  input logic       rst,
  mb_pix_if.sink    pix,
  mb_res_if.source  res,
  mb_cfg_if.sink    cfg
);

  cfg_t cfg_q;
  res_t core_res;
  res_t res_q;
  logic out_valid;
  logic core_idle;
  logic core_done;
  logic load;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.origin_x <= ORIGIN_RST;
      cfg_q.origin_y <= ORIGIN_RST;
      cfg_q.step_x   <= STEP_RST;
      cfg_q.step_y   <= STEP_RST;
      cfg_q.max_iter <= MAX_ITER_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ORIGIN_X: cfg_q.origin_x <= cfg.data;
        REG_ORIGIN_Y: cfg_q.origin_y <= cfg.data;
        REG_STEP_X:   cfg_q.step_x   <= cfg.data;
        REG_STEP_Y:   cfg_q.step_y   <= cfg.data;
        REG_MAX_ITER: cfg_q.max_iter <= cfg.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign pix.ready = core_idle;
  assign load      = core_done && (!out_valid || res.ready);

  mb_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (pix.valid),
    .col      (pix.pixel_col),
    .row      (pix.pixel_row),
    .cfg      (cfg_q),
    .idle     (core_idle),
    .done     (core_done),
    .done_ack (load),
    .res      (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_q <= core_res;
  end

  assign res.valid      = out_valid;
  assign res.out_col    = res_q.out_col;
  assign res.out_row    = res_q.out_row;
  assign res.iter_count = res_q.iter_count;
  assign res.escaped    = res_q.escaped;
  assign res.final_re   = res_q.final_re;
  assign res.final_im   = res_q.final_im;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    pix.valid && pix.ready |=> !pix.ready)
    else $error("input taken while a pixel is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.iter_count <= cfg_q.max_iter)
    else $error("iteration count beyond limit");

  a_limit_exit: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.escaped |-> res.iter_count == cfg_q.max_iter)
    else $error("non-escaped result stopped before the limit");

  a_load_only_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(core_done))
    else $error("result loaded without a finished pixel");
`endif

endmodule

// ===== hw/rtl/mb_mul.sv =====
// Shared registered 32x32 signed multiplier.
module mb_mul import mb_pkg::*; (
  input  logic                     clk,
  input  logic signed [WORD_W-1:0] a,
  input  logic signed [WORD_W-1:0] b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// ===== hw/rtl/mb_core.sv =====
// Iteration sequencer and datapath around the shared multiplier.
module mb_core import mb_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [POS_W-1:0] col,
  input  logic [POS_W-1:0] row,
  input  cfg_t             cfg,
  output logic             idle,
  output logic             done,
  input  logic             done_ack,
  output res_t             res
);

  localparam int THR_SHIFT = 2 * FRAC_BITS + 2;
  localparam bit ESC_EN = (THR_SHIFT <= PROD_W - 1);
  localparam logic [PROD_W-1:0] THRESH = ESC_EN ? (64'd1 << THR_SHIFT) : '1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CX   = 3'd1;
  localparam logic [2:0] S_CY   = 3'd2;
  localparam logic [2:0] S_RR   = 3'd3;
  localparam logic [2:0] S_II   = 3'd4;
  localparam logic [2:0] S_RI   = 3'd5;
  localparam logic [2:0] S_UPD  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[WORD_W-1:0];
    end
  endfunction

  logic [2:0]               state;
  logic [POS_W-1:0]         col_r;
  logic [POS_W-1:0]         row_r;
  logic signed [WORD_W-1:0] zr;
  logic signed [WORD_W-1:0] zi;
  logic signed [WORD_W-1:0] cr;
  logic signed [WORD_W-1:0] ci;
  logic signed [PROD_W-1:0] rr;
  logic signed [PROD_W-1:0] ii;
  logic [CNT_W-1:0]         count;
  logic                     esc;

  logic signed [WORD_W-1:0] mul_a;
  logic signed [WORD_W-1:0] mul_b;
  logic signed [PROD_W-1:0] p;
  logic [PROD_W-1:0]        mag;
  logic                     over;
  logic signed [PROD_W-1:0] re_sum;
  logic signed [PROD_W-1:0] im_sum;

  mb_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  always_comb begin
    case (state)
      S_CX: begin
        mul_a = {{(WORD_W-POS_W){1'b0}}, col_r};
        mul_b = cfg.step_x;
      end
      S_CY: begin
        mul_a = {{(WORD_W-POS_W){1'b0}}, row_r};
        mul_b = cfg.step_y;
      end
      S_RR: begin
        mul_a = zr;
        mul_b = zr;
      end
      S_II: begin
        mul_a = zi;
        mul_b = zi;
      end
      default: begin
        mul_a = zr;
        mul_b = zi;
      end
    endcase
  end

  // p holds zi*zi in S_RI and zr*zi in S_UPD
  assign mag    = $unsigned(rr) + $unsigned(p);
  assign over   = ESC_EN && (mag > THRESH);
  assign re_sum = ((rr - ii) >>> FRAC_BITS) + PROD_W'(cr);
  assign im_sum = (p >>> (FRAC_BITS - 1)) + PROD_W'(ci);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (start) state <= S_CX;
        S_CX:   state <= S_CY;
        S_CY:   state <= S_RR;
        S_RR:   state <= S_II;
        S_II:   state <= S_RI;
        S_RI:   state <= (over || count == cfg.max_iter) ? S_DONE : S_UPD;
        S_UPD:  state <= S_RR;
        S_DONE: if (done_ack) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          col_r <= col;
          row_r <= row;
          zr    <= '0;
          zi    <= '0;
          count <= '0;
          esc   <= 1'b0;
        end
      end
      S_CY: cr <= sat32(PROD_W'(cfg.origin_x) + p);
      // row*step_y only on the first pass, before any update
      S_RR: if (count == '0) ci <= sat32(PROD_W'(cfg.origin_y) + p);
      S_II: rr <= p;
      S_RI: begin
        ii  <= p;
        esc <= over;
      end
      S_UPD: begin
        zr    <= sat32(re_sum);
        zi    <= sat32(im_sum);
        count <= count + 1'b1;
      end
      default: ;
    endcase
  end

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);

  assign res.out_col    = col_r;
  assign res.out_row    = row_r;
  assign res.iter_count = count;
  assign res.escaped    = esc;
  assign res.final_re   = zr;
  assign res.final_im   = zi;

endmodule
